// ===== hw/rtl/rcc_pkg.sv =====
// Shared widths and pipeline word types for the rectangle-circle contact block.
package rcc_pkg;

  localparam int COORD_BITS = 24;
  localparam int NORM_FRAC  = 14;
  localparam int NORM_W     = 16;
  localparam int RAD_W      = COORD_BITS - 1;
  localparam int DMAG_W     = COORD_BITS + 1;
  localparam int SQ_W       = 2 * DMAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int DIV_W      = ROOT_W + NORM_FRAC;
  localparam int QUO_W      = NORM_FRAC + 1;

  typedef struct packed {
    logic              neg_x;
    logic              neg_y;
    logic [DMAG_W-1:0] mag_x;
    logic [DMAG_W-1:0] mag_y;
    logic [RAD_W-1:0]  rad;
  } sq_side_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rest;
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_st_t;

  typedef struct packed {
    logic [DIV_W-1:0]  rem_x;
    logic [DIV_W-1:0]  rem_y;
    logic [DIV_W-1:0]  dsh;
    logic [QUO_W-1:0]  q_x;
    logic [QUO_W-1:0]  q_y;
    logic              neg_x;
    logic              neg_y;
    logic [ROOT_W-1:0] len;
    logic [RAD_W-1:0]  rad;
  } dv_st_t;

endpackage

// ===== hw/rtl/rcc_sqrt_cell.sv =====
// One digit cell of the square root chain: settles one root bit per word.
module rcc_sqrt_cell import rcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_v,
  input  sq_st_t   in_st,
  input  sq_side_t in_side,
  output logic     out_v,
  output sq_st_t   out_st,
  output sq_side_t out_side
);

  logic [ROOT_W+1:0] rem_w;
  logic [ROOT_W+1:0] trial;
  logic              ge;
  logic              v_r;
  sq_st_t            st_r;
  sq_st_t            st_nxt;
  sq_side_t          side_r;

  always_comb begin
    rem_w  = {in_st.rem[ROOT_W-1:0], in_st.rest[SUM_W-1 -: 2]};
    trial  = {in_st.root, 2'b01};
    ge     = (rem_w >= trial);
    st_nxt.rest = {in_st.rest[SUM_W-3:0], 2'b00};
    st_nxt.rem  = ge ? (rem_w - trial) : rem_w;
    st_nxt.root = {in_st.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) begin
      st_r   <= st_nxt;
      side_r <= in_side;
    end
  end

  assign out_v    = v_r;
  assign out_st   = st_r;
  assign out_side = side_r;

endmodule

// ===== hw/rtl/rcc_div_cell.sv =====
// One cell of the normal divider chain: settles one quotient bit for x and for y.
module rcc_div_cell import rcc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_v,
  input  dv_st_t in_st,
  output logic   out_v,
  output dv_st_t out_st
);

  logic   ge_x;
  logic   ge_y;
  logic   v_r;
  dv_st_t st_r;
  dv_st_t st_nxt;

  always_comb begin
    st_nxt = in_st;
    ge_x   = (in_st.rem_x >= in_st.dsh);
    ge_y   = (in_st.rem_y >= in_st.dsh);
    st_nxt.rem_x = ge_x ? (in_st.rem_x - in_st.dsh) : in_st.rem_x;
    st_nxt.rem_y = ge_y ? (in_st.rem_y - in_st.dsh) : in_st.rem_y;
    st_nxt.q_x   = {in_st.q_x[QUO_W-2:0], ge_x};
    st_nxt.q_y   = {in_st.q_y[QUO_W-2:0], ge_y};
    st_nxt.dsh   = {1'b0, in_st.dsh[DIV_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_v;
    end
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_v  = v_r;
  assign out_st = st_r;

endmodule

// ===== hw/rtl/rect_circle_contact.sv =====
// Top level of the rectangle-circle contact pipeline.
// Pipeline: 5 front stages, 26 square root cells, 15 divider cells and the output
// register lie between an accepted word and its result word.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset (synchronous, active low) clears every stage valid bit and the output valid.
module rect_circle_contact import rcc_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_rect_x,
  input  logic signed [COORD_BITS-1:0] in_rect_y,
  input  logic        [RAD_W-1:0]      in_rect_w,
  input  logic        [RAD_W-1:0]      in_rect_h,
  input  logic signed [COORD_BITS-1:0] in_circle_x,
  input  logic signed [COORD_BITS-1:0] in_circle_y,
  input  logic        [RAD_W-1:0]      in_radius,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_hit,
  output logic signed [NORM_W-1:0]     out_normal_x,
  output logic signed [NORM_W-1:0]     out_normal_y,
  output logic        [RAD_W-1:0]      out_depth
);

  logic adv;

  logic                         v1_r;
  logic signed [COORD_BITS:0]   lx1_r, hx1_r, cx1_r, ly1_r, hy1_r, cy1_r;
  logic        [RAD_W-1:0]      rad1_r;

  logic                         v2_r;
  logic signed [COORD_BITS+1:0] dx2_r, dy2_r;
  logic        [RAD_W-1:0]      rad2_r;
  logic signed [COORD_BITS:0]   px_c, py_c;

  logic                         v3_r;
  sq_side_t                     side3_r;

  logic                         v4_r;
  logic        [SQ_W-1:0]       sx4_r, sy4_r;
  sq_side_t                     side4_r;

  logic                         v5_r;
  sq_st_t                       st5_r;
  sq_side_t                     side5_r;

  logic     sq_v    [ROOT_W+1];
  sq_st_t   sq_st   [ROOT_W+1];
  sq_side_t sq_side [ROOT_W+1];

  logic   dv_v  [QUO_W+1];
  dv_st_t dv_st [QUO_W+1];

  logic                     out_valid_r;
  logic                     hit_r;
  logic signed [NORM_W-1:0] nx_r, ny_r;
  logic [RAD_W-1:0]         depth_r;
  logic                     hit_c;
  logic                     nz_c;
  logic signed [NORM_W-1:0] qx_c, qy_c;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    px_c = cx1_r;
    if (cx1_r < lx1_r) px_c = lx1_r;
    if (cx1_r > hx1_r) px_c = hx1_r;
    py_c = cy1_r;
    if (cy1_r < ly1_r) py_c = ly1_r;
    if (cy1_r > hy1_r) py_c = hy1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (adv) begin
      lx1_r  <= {in_rect_x[COORD_BITS-1], in_rect_x};
      hx1_r  <= $signed({in_rect_x[COORD_BITS-1], in_rect_x}) + $signed({2'b00, in_rect_w});
      cx1_r  <= {in_circle_x[COORD_BITS-1], in_circle_x};
      ly1_r  <= {in_rect_y[COORD_BITS-1], in_rect_y};
      hy1_r  <= $signed({in_rect_y[COORD_BITS-1], in_rect_y}) + $signed({2'b00, in_rect_h});
      cy1_r  <= {in_circle_y[COORD_BITS-1], in_circle_y};
      rad1_r <= in_radius;

      dx2_r  <= $signed({cx1_r[COORD_BITS], cx1_r}) - $signed({px_c[COORD_BITS], px_c});
      dy2_r  <= $signed({cy1_r[COORD_BITS], cy1_r}) - $signed({py_c[COORD_BITS], py_c});
      rad2_r <= rad1_r;

      side3_r.neg_x <= dx2_r[COORD_BITS+1];
      side3_r.neg_y <= dy2_r[COORD_BITS+1];
      side3_r.mag_x <= dx2_r[COORD_BITS+1] ? DMAG_W'(-dx2_r) : DMAG_W'(dx2_r);
      side3_r.mag_y <= dy2_r[COORD_BITS+1] ? DMAG_W'(-dy2_r) : DMAG_W'(dy2_r);
      side3_r.rad   <= rad2_r;

      sx4_r   <= side3_r.mag_x * side3_r.mag_x;
      sy4_r   <= side3_r.mag_y * side3_r.mag_y;
      side4_r <= side3_r;

      st5_r.rest <= SUM_W'(sx4_r) + SUM_W'(sy4_r);
      st5_r.rem  <= '0;
      st5_r.root <= '0;
      side5_r    <= side4_r;
    end
  end

  assign sq_v[0]    = v5_r;
  assign sq_st[0]   = st5_r;
  assign sq_side[0] = side5_r;

  for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
    rcc_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (adv),
      .in_v     (sq_v[i]),
      .in_st    (sq_st[i]),
      .in_side  (sq_side[i]),
      .out_v    (sq_v[i+1]),
      .out_st   (sq_st[i+1]),
      .out_side (sq_side[i+1])
    );
  end

  always_comb begin
    dv_v[0]        = sq_v[ROOT_W];
    dv_st[0].rem_x = DIV_W'(sq_side[ROOT_W].mag_x) << NORM_FRAC;
    dv_st[0].rem_y = DIV_W'(sq_side[ROOT_W].mag_y) << NORM_FRAC;
    dv_st[0].dsh   = DIV_W'(sq_st[ROOT_W].root) << NORM_FRAC;
    dv_st[0].q_x   = '0;
    dv_st[0].q_y   = '0;
    dv_st[0].neg_x = sq_side[ROOT_W].neg_x;
    dv_st[0].neg_y = sq_side[ROOT_W].neg_y;
    dv_st[0].len   = sq_st[ROOT_W].root;
    dv_st[0].rad   = sq_side[ROOT_W].rad;
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    rcc_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (adv),
      .in_v   (dv_v[k]),
      .in_st  (dv_st[k]),
      .out_v  (dv_v[k+1]),
      .out_st (dv_st[k+1])
    );
  end

  always_comb begin
    hit_c = (dv_st[QUO_W].len <= ROOT_W'(dv_st[QUO_W].rad));
    nz_c  = hit_c && (dv_st[QUO_W].len != '0);
    qx_c  = dv_st[QUO_W].neg_x ? -$signed({1'b0, dv_st[QUO_W].q_x})
                               : $signed({1'b0, dv_st[QUO_W].q_x});
    qy_c  = dv_st[QUO_W].neg_y ? -$signed({1'b0, dv_st[QUO_W].q_y})
                               : $signed({1'b0, dv_st[QUO_W].q_y});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_v[QUO_W];
    end
    if (adv) begin
      hit_r   <= hit_c;
      nx_r    <= nz_c ? qx_c : '0;
      ny_r    <= nz_c ? qy_c : '0;
      depth_r <= hit_c ? (dv_st[QUO_W].rad - dv_st[QUO_W].len[RAD_W-1:0]) : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = hit_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;
  assign out_depth    = depth_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output word valid right after reset.");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_normal_x == '0 && out_normal_y == '0 && out_depth == '0)
    else $error("Miss word carries a nonzero normal or depth.");

  a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16'sd16384 && out_normal_x >= -16'sd16384 &&
                  out_normal_y <= 16'sd16384 && out_normal_y >= -16'sd16384)
    else $error("Normal component outside the unit range.");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_depth) && $stable(out_hit))
    else $error("Pending result word changed while stalled.");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the rectangle-circle contact pipeline.
module tb_top;
  import rcc_pkg::*;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [COORD_BITS-1:0] in_rect_x, in_rect_y, in_circle_x, in_circle_y;
  logic [RAD_W-1:0] in_rect_w, in_rect_h, in_radius;
  logic out_hit;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y;
  logic [RAD_W-1:0] out_depth;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] rx, ry;
    logic [RAD_W-1:0] rw, rh;
    logic signed [COORD_BITS-1:0] cx, cy;
    logic [RAD_W-1:0] rad;
  } query_t;

  typedef struct packed {
    logic hit;
    logic [NORM_W-1:0] nx, ny;
    logic [RAD_W-1:0] depth;
  } contact_t;

  typedef struct {
    query_t q;
    logic known;
    contact_t c;
  } row_t;

  contact_t pending[$];
  int errors = 0;
  int cycles = 0;
  logic hold_long = 0;
  logic stim_done = 0;
  logic late = 0;

  rect_circle_contact dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic logic [32:0] root66(logic [65:0] v);
    logic [32:0] root;
    logic [67:0] rem, trial;
    root = 0;
    rem = 0;
    for (int g = 32; g >= 0; g--) begin
      rem = (rem << 2) | v[2*g +: 2];
      trial = {root, 2'b01};
      if (rem >= trial) begin
        rem = rem - trial;
        root = {root[31:0], 1'b1};
      end else begin
        root = {root[31:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic logic [NORM_W-1:0] unit_comp(longint d, logic [32:0] len);
    longint unsigned mag, quo;
    if (len == 0) return '0;
    mag = (d < 0) ? -d : d;
    quo = (mag << NORM_FRAC) / len;
    if (d < 0) quo = -quo;
    return quo[NORM_W-1:0];
  endfunction

  function automatic contact_t contact_of(query_t q);
    longint px, py, dx, dy;
    longint unsigned ax, ay;
    logic [65:0] sum;
    logic [32:0] len;
    contact_t c;
    px = q.cx;
    if (px < longint'(q.rx)) px = q.rx;
    if (px > longint'(q.rx) + longint'(q.rw)) px = longint'(q.rx) + longint'(q.rw);
    py = q.cy;
    if (py < longint'(q.ry)) py = q.ry;
    if (py > longint'(q.ry) + longint'(q.rh)) py = longint'(q.ry) + longint'(q.rh);
    dx = longint'(q.cx) - px;
    dy = longint'(q.cy) - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sum = 66'(ax * ax) + 66'(ay * ay);
    len = root66(sum);
    c = '0;
    if (len <= q.rad) begin
      c.hit = 1;
      c.nx = unit_comp(dx, len);
      c.ny = unit_comp(dy, len);
      c.depth = RAD_W'(q.rad - len);
    end
    return c;
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int mode;
    mode = $urandom_range(0, 3);
    q.rx = $urandom;
    q.ry = $urandom;
    q.rw = $urandom;
    q.rh = $urandom;
    q.cx = $urandom;
    q.cy = $urandom;
    q.rad = $urandom;
    if (mode != 0) begin
      q.rw = $urandom_range(0, 4096);
      q.rh = $urandom_range(0, 4096);
      q.cx = q.rx + $signed($urandom_range(0, 8192)) - 2048;
      q.cy = q.ry + $signed($urandom_range(0, 8192)) - 2048;
      q.rad = (mode == 3) ? $urandom : $urandom_range(0, 4096);
    end
    return q;
  endfunction

  task automatic send(query_t q);
    int gap;
    if (!late && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {in_rect_x, in_rect_y, in_rect_w, in_rect_h, in_circle_x, in_circle_y, in_radius} <= q;
    pending.push_back(contact_of(q));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  row_t rows[$];

  task automatic add_row(query_t q, logic known, contact_t c);
    row_t r;
    r.q = q;
    r.known = known;
    r.c = c;
    rows.push_back(r);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    {in_rect_x, in_rect_y, in_rect_w, in_rect_h, in_circle_x, in_circle_y, in_radius} = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    add_row('0, 1, '{1'b1, 16'd0, 16'd0, 23'd0});
    add_row('{0, 0, 100, 100, 50, 50, 23'h7FFFFF}, 1, '{1'b1, 16'd0, 16'd0, 23'h7FFFFF});
    add_row('{0, 0, 0, 0, 256, 0, 256}, 1, '{1'b1, 16'd16384, 16'd0, 23'd0});
    add_row('{0, 0, 0, 0, -256, 0, 512}, 1, '{1'b1, 16'hC000, 16'd0, 23'd256});
    add_row('{0, 0, 0, 0, 0, 1000, 10}, 1, '0);
    add_row('{24'sh800000, 24'sh800000, 0, 0, 24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF}, 1, '0);
    add_row('{24'sh7FFFFF, 24'sh7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 24'sh800000, 24'sh800000,
              23'h7FFFFF}, 1, '0);
    add_row('{24'sh800000, 24'sh800000, 23'h7FFFFF, 23'h7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              23'h7FFFFF}, 0, '0);
    add_row('{0, 0, 10, 10, 13, 14, 5}, 0, '0);
    add_row('{0, 0, 10, 10, -3, -4, 5}, 0, '0);
    add_row('{0, 0, 10, 10, 10, 10, 0}, 0, '0);
    add_row('{0, 0, 10, 10, 11, 11, 1}, 0, '0);
    add_row('{0, 0, 0, 0, 3, 3, 4}, 0, '0);
    add_row('{-5, -5, 3, 3, -20, 8, 23'h7FFFFF}, 0, '0);
    foreach (rows[i]) begin
      send(rows[i].q);
      if (rows[i].known) pending[$] = rows[i].c;
    end
    in_valid <= 0;
    while (pending.size() != 0) @(posedge clk);
    hold_long <= 1;
    for (int i = 0; i < 500; i++) begin
      if (i == 100) hold_long <= 0;
      if (i == 420) late = 1;
      send(rand_query());
    end
    in_valid <= 0;
    stim_done <= 1;
  end

  initial begin
    int gap;
    logic held;
    out_ready = 0;
    held = 0;
    @(posedge rst_n);
    forever begin
      if (hold_long && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (300) @(posedge clk);
      end else if (!late && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        gap = $urandom_range(1, 16);
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    contact_t c;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        c = pending.pop_front();
        if (out_hit !== c.hit) begin
          $error("hit: expected %0d, got %0d", c.hit, out_hit);
          errors++;
        end
        if (out_normal_x !== c.nx) begin
          $error("normal_x: expected %0d, got %0d", $signed(c.nx), out_normal_x);
          errors++;
        end
        if (out_normal_y !== c.ny) begin
          $error("normal_y: expected %0d, got %0d", $signed(c.ny), out_normal_y);
          errors++;
        end
        if (out_depth !== c.depth) begin
          $error("depth: expected %0d, got %0d", c.depth, out_depth);
          errors++;
        end
      end
    end
  end

  initial begin
    @(posedge stim_done);
    while (pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && pending.size() == 0 && !out_valid)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 200000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_sqrt_cell.sv
hw/rtl/rcc_div_cell.sv
hw/rtl/rect_circle_contact.sv
test/tb_top.sv
